FILE: rtl/lru_key_value_cache_unit_assert.svh
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit_assert.svh
// Assertion macros shared by the cache checker.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define LKVC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define LKVC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

FILE: rtl/lkvc_pkg.sv
// ---------------------------------------------------------------------------
// lkvc_pkg
// Types and constants of the LRU key/value cache.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

    // request codes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    // capacity register
    localparam int unsigned CAP_BITS  = 4;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic hit;   // accepted item hit: promote the matching cell
        logic ins;   // accepted write missed: shift everything, new at head
    } t_cell_ctl;

endpackage

FILE: rtl/lkvc_cell.sv
// ---------------------------------------------------------------------------
// lkvc_cell
// One recency slot of the chain: key, value, valid, and key compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic                  i_found,     // match in a younger cell
    input  logic                  i_in_cap,    // slot index below capacity
    input  logic [KEY_BITS-1:0]   i_key,       // searched key
    input  logic [KEY_BITS-1:0]   i_nb_key,    // younger neighbor (or head)
    input  logic [VALUE_BITS-1:0] i_nb_value,
    input  logic                  i_nb_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_valid,
    output logic                  o_match,
    output logic                  o_found
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid;
    logic                  n_valid;
    logic                  load;

    assign o_match = r_valid && (r_key == i_key);
    assign o_found = i_found | o_match;

    // promote on hit: cells up to the hit slot take their neighbor
    assign load    = i_ctl.ins | (i_ctl.hit & ~i_found);
    // on insert, slots past capacity fall off
    assign n_valid = i_nb_valid & (i_in_cap | i_ctl.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

FILE: rtl/lru_key_value_cache_unit.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | into unit | i_in_valid / o_in_stall | i_mode, i_key, i_value
//  out      | from unit | o_out_valid / i_out_stall | o_hit, o_read_data
//  cfg      | into unit | i_cfg_we               | i_cfg_wdata (capacity)
//
//  One item per clock while o_in_stall is low: the item is searched and
//  the chain updated at the accepting edge, its result lands in the output
//  register. The throughput is set by the combinational compare across
//  the cell chain plus the promote/shift of the chain.
//  A stalled result holds the input side only while the output register is
//  full and stalled; o_in_stall is also high during reset.
//  Reset (i_rst_n low, synchronous) empties the chain and sets capacity to 8.
//
//  Organization: cell 0 holds the most recent entry, cell N-1 the oldest.
//  The valid cells are always a contiguous run starting at cell 0, so an
//  entry's rank is its cell index.
//    hit    : the matching cell moves to the head, younger cells shift down
//             by one, older cells hold. A write also updates the value.
//    insert : (write miss) every cell shifts down, the new entry enters at
//             the head, and cells at or beyond capacity drop out. With the
//             capacity lowered below the fill level this drops all the
//             overflow at once.
//    lookup miss: no change, result hit 0 / data 0.
//  Capacity 0 acts as 1; capacity above the cell count acts as full depth.
// ---------------------------------------------------------------------------

module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int unsigned ENTRIES    = 8,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CAP_BITS-1:0]   i_cfg_wdata,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_read_data
);

    localparam int unsigned CAP_SPAN = 1 << CAP_BITS;

    // capacity register
    logic [CAP_BITS-1:0]   r_capacity;

    // output register
    logic                  r_out_valid;
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_read_data;

    // chain wiring
    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic                  cell_valid [ENTRIES];
    logic [ENTRIES-1:0]    cell_match;
    logic [ENTRIES-1:0]    cell_found;
    logic [ENTRIES-1:0]    cell_in_cap;

    logic                  accept;
    logic                  found_any;
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] head_value;
    t_cell_ctl             ctl;

    // ---------------- handshake ----------------
    assign o_in_stall = ~i_rst_n | (r_out_valid & i_out_stall);
    assign accept     = i_in_valid & ~o_in_stall;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // ---------------- search result ----------------
    assign found_any = cell_found[ENTRIES-1];

    // the match vector is one-hot or empty: plain OR select
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | ({VALUE_BITS{cell_match[i]}} & cell_value[i]);
        end
    end

    assign ctl.hit = accept & found_any;
    assign ctl.ins = accept & ~found_any & (i_mode == MODE_WRITE);

    // entry entering the head: new data on a write, the old value on a lookup
    assign head_value = (i_mode == MODE_WRITE) ? i_value : hit_value;

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        // slot index below capacity; slot 0 always in (capacity 0 acts as 1)
        if (g == 0) begin : g_cap_head
            assign cell_in_cap[g] = 1'b1;
        end else if (g >= CAP_SPAN) begin : g_cap_out
            assign cell_in_cap[g] = 1'b0;
        end else begin : g_cap_cmp
            assign cell_in_cap[g] = (r_capacity > CAP_BITS'(g));
        end

        if (g == 0) begin : g_head
            lkvc_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_found    (1'b0),
                .i_in_cap   (cell_in_cap[g]),
                .i_key      (i_key),
                .i_nb_key   (i_key),
                .i_nb_value (head_value),
                .i_nb_valid (1'b1),
                .o_key      (cell_key[g]),
                .o_value    (cell_value[g]),
                .o_valid    (cell_valid[g]),
                .o_match    (cell_match[g]),
                .o_found    (cell_found[g])
            );
        end else begin : g_body
            lkvc_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_found    (cell_found[g-1]),
                .i_in_cap   (cell_in_cap[g]),
                .i_key      (i_key),
                .i_nb_key   (cell_key[g-1]),
                .i_nb_value (cell_value[g-1]),
                .i_nb_valid (cell_valid[g-1]),
                .o_key      (cell_key[g]),
                .o_value    (cell_value[g]),
                .o_valid    (cell_valid[g]),
                .o_match    (cell_match[g]),
                .o_found    (cell_found[g])
            );
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit       <= found_any;
            r_read_data <= (found_any && (i_mode == MODE_LOOKUP)) ? hit_value : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_read_data = r_read_data;

endmodule

FILE: rtl/lkvc_checker.sv
// ---------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key/value cache, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_assert.svh"

module lkvc_checker
    import lkvc_pkg::*;
#(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_mode,
    input logic [KEY_BITS-1:0]   i_key,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_hit,
    input logic [VALUE_BITS-1:0] o_read_data
);

    logic                in_acc;
    logic                wr_then_rd;
    logic                r_prev_wr;
    logic [KEY_BITS-1:0] r_prev_key;

    assign in_acc = i_in_valid & ~o_in_stall;

    // previous cycle: accepted write and its key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_wr <= 1'b0;
        end else begin
            r_prev_wr <= in_acc && (i_mode == MODE_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_key <= i_key;
    end

    // a lookup right after a write of the same key
    assign wr_then_rd = in_acc && (i_mode == MODE_LOOKUP) && r_prev_wr
                        && (r_prev_key == i_key);

    // each accepted item shows a result on the next cycle
    `LKVC_ASSERT_NXT(a_result_follows, in_acc, o_out_valid)

    // a stalled result holds
    `LKVC_ASSERT_NXT(a_result_holds, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_hit) && $stable(o_read_data))

    // a miss never carries data
    `LKVC_ASSERT_IMP(a_miss_zero, o_out_valid && !o_hit, o_read_data == '0)

    // a key just written is the most recent entry and must hit
    `LKVC_ASSERT_NXT(a_write_then_hit, wr_then_rd, o_hit)

endmodule

bind lru_key_value_cache_unit lkvc_checker #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (.*);

FILE: test/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// Self-checking bench for the LRU key/value cache: a shadow copy of the
// cache predicts hit and read data for every accepted item, and each
// result is checked in order. Capacity sweeps through normal, zero,
// saturating and shrinking settings, and both channels idle and stall at
// random.
// ---------------------------------------------------------------------------

typedef struct {
    logic        hit;
    logic [31:0] data;
} cache_result_t;

class lru_scoreboard;
    localparam int SLOTS = 8;

    logic [31:0]   slot_key [SLOTS];
    logic [31:0]   slot_val [SLOTS];
    bit            slot_live [SLOTS];
    int unsigned   slot_age [SLOTS];
    int unsigned   live_count;
    logic [3:0]    cap_reg;
    cache_result_t due_results [$];
    int            errors;

    function new();
        foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        live_count = 0;
        cap_reg    = lkvc_pkg::CAP_RESET;
        errors     = 0;
    endfunction

    function void set_capacity(logic [3:0] c);
        cap_reg = c;
    endfunction

    // Shadow the cache update for one accepted item and queue its result.
    function void note_access(logic m, logic [31:0] k, logic [31:0] v);
        cache_result_t res;
        int            found;
        int            slot;
        int unsigned   age;
        int unsigned   cap;
        res.hit  = 1'b0;
        res.data = '0;
        found    = -1;
        foreach (slot_live[i]) begin
            if (found < 0 && slot_live[i] && slot_key[i] == k)
                found = i;
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            if (m == lkvc_pkg::MODE_LOOKUP)
                res.data = slot_val[found];
            else
                slot_val[found] = v;
            // promote: younger entries age by one
            age = slot_age[found];
            foreach (slot_live[i]) begin
                if (slot_live[i] && slot_age[i] < age)
                    slot_age[i]++;
            end
            slot_age[found] = 0;
        end else if (m == lkvc_pkg::MODE_WRITE) begin
            cap = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
            // full (or over a lowered capacity): drop every entry of rank cap-1 and older
            if (live_count >= cap) begin
                foreach (slot_live[i]) begin
                    if (slot_live[i] && slot_age[i] >= cap - 1) begin
                        slot_live[i] = 1'b0;
                        slot_age[i]  = 0;
                    end
                end
            end
            live_count = 0;
            slot       = -1;
            foreach (slot_live[i]) begin
                if (slot_live[i]) begin
                    slot_age[i]++;
                    live_count++;
                end else if (slot < 0) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                slot_key[slot]  = k;
                slot_val[slot]  = v;
                slot_live[slot] = 1'b1;
                slot_age[slot]  = 0;
                live_count++;
            end
        end
        due_results.push_back(res);
    endfunction

    function void check_result(logic h, logic [31:0] d);
        cache_result_t want;
        if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: hit=%0b data=%08h", h, d);
        end else begin
            want = due_results.pop_front();
            if (h !== want.hit || d !== want.data) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: hit exp %0b got %0b, data exp %08h got %08h",
                             want.hit, h, want.data, d);
            end
        end
    endfunction

    function void check_drained();
        while (due_results.size() != 0) begin
            errors++;
            if (errors <= 10)
                $display("missing result: hit=%0b data=%08h",
                         due_results[0].hit, due_results[0].data);
            void'(due_results.pop_front());
        end
    endfunction
endclass

module lru_key_value_cache_unit_tb;
    import lkvc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;   // cycles with no accepted traffic
    localparam int HOLD_CYCLES = 80;     // long receiver hold-off
    localparam int PHASE_ITEMS = 152;
    localparam int POOL_SIZE   = 12;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CAP_BITS-1:0] i_cfg_wdata = '0;
    logic                i_in_valid  = 1'b0;
    logic                i_mode      = MODE_LOOKUP;
    logic [31:0]         i_key       = '0;
    logic [31:0]         i_value     = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_hit;
    logic [31:0]         o_read_data;

    lru_key_value_cache_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_read_data (o_read_data)
    );

    lru_scoreboard sb = new();

    // Shared knobs between the stimulus and the stall process.
    bit          quiet    = 1'b0;   // no gaps and no stalls this phase
    bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
    logic [31:0] key_pool [POOL_SIZE];
    int          idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Result side: stall runs, mostly short, now and then long. A hold
    // request turns into one long stall, counted here, while the sender
    // keeps offering items so the cache backs up into its input.
    // ---------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;
    bit stall_now  = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                if (quiet) begin
                    stall_now  = 1'b0;
                    stall_left = 16;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_now  = 1'b1;
                    stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                             : $urandom_range(1, 3);
                end else begin
                    stall_now  = 1'b0;
                    stall_left = $urandom_range(1, 12);
                end
            end
            stall_left--;
            i_out_stall <= stall_now;
        end
    end

    // Results are taken at the rising edge with the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_hit, o_read_data);
    end

    // Watchdog: ends a run that stops moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("lru_key_value_cache_unit_tb: errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Request side. Tasks start and end at a falling edge.
    // ---------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Offer one item and hold it until accepted.
    task automatic send_item(logic m, logic [31:0] k, logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_key      <= k;
        i_value    <= v;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                sb.note_access(m, k, v);
                break;
            end
        end
        @(negedge i_clk);
    endtask

    // Capacity changes only with the cache idle: input quiet, results drained.
    task automatic write_capacity(logic [3:0] c);
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        sb.set_capacity(c);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Fresh keys per phase; a neighbor key and the extremes keep the
    // compare honest on single-bit differences.
    task automatic refresh_pool();
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[1] = key_pool[0] ^ (32'h1 << $urandom_range(0, 31));
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
    endtask

    task automatic send_random();
        logic        m;
        logic [31:0] k;
        logic [31:0] v;
        int          vr;
        m  = 1'($urandom_range(0, 1));
        k  = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        vr = $urandom_range(0, 15);
        v  = (vr == 0) ? 32'h0 : ((vr == 1) ? 32'hFFFF_FFFF : $urandom);
        send_item(m, k, v);
    endtask

    logic [3:0] cap_plan [12] = '{4'd1, 4'd2, 4'd8, 4'd12, 4'd4, 4'd0,
                                  4'd6, 4'd3, 4'd15, 4'd5, 4'd7, 4'd8};

    initial begin : stimulus
        int spin;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: capacity above the cell count saturates to full depth.
        write_capacity(4'd15);
        send_item(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);   // miss on empty
        send_item(MODE_WRITE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_item(MODE_WRITE,  32'hFFFF_FFFF, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_WRITE,  32'h0000_0000, 32'h5A5A_A5A5);   // write to present key
        send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        for (int i = 1; i <= 6; i++)
            send_item(MODE_WRITE, i, 32'h1000_0000 + i);          // fills all eight
        send_item(MODE_WRITE,  32'h0000_0100, 32'hCAFE_0100);   // evicts the oldest
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000);

        // Capacity lowered below the fill level: only an insert trims.
        write_capacity(4'd3);
        send_item(MODE_LOOKUP, 32'h0000_0002, 32'h0000_0000);
        send_item(MODE_WRITE,  32'h0000_0002, 32'h2222_2222);
        send_item(MODE_WRITE,  32'h0000_0200, 32'h0200_0200);   // drops the overflow at once
        send_item(MODE_LOOKUP, 32'h0000_0003, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000);

        // Capacity zero behaves as one entry.
        write_capacity(4'd0);
        send_item(MODE_WRITE,  32'h0000_AAAA, 32'hAAAA_0000);
        send_item(MODE_WRITE,  32'h0000_5555, 32'h5555_0000);
        send_item(MODE_LOOKUP, 32'h0000_AAAA, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0000_5555, 32'h0000_0000);

        // Random phases over the capacity plan; every fourth runs flat out.
        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            refresh_pool();
            quiet = (p % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 10)
                    hold_req = 1'b1;
                send_random();
            end
        end

        i_in_valid <= 1'b0;
        spin = 0;
        while (sb.due_results.size() != 0 && spin < IDLE_LIMIT) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (4) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("lru_key_value_cache_unit_tb: clean");
        else
            $display("lru_key_value_cache_unit_tb: errors");
        $finish;
    end

endmodule
